/* src/stt_pkg.sv */
// Shared types, field widths, request and register codes for the timer table.
package stt_pkg;

	// Fixed field widths of the request and event channels
	localparam int REQ_W      = 2;
	localparam int LEVEL_W    = 2;
	localparam int SLOT_W     = 3;
	localparam int EVT_SLOT_W = 2;

	// Configuration layout: three levels have registers, one byte per slot
	localparam int CFG_LEVELS  = 3;
	localparam int FIELD_W     = 8;
	localparam int MASK_W      = 12;
	localparam int MASK_STRIDE = 4;

	// APB port
	localparam int DATA_W    = 32;
	localparam int REG_COUNT = 8;
	localparam int REG_IDX_W = $clog2(REG_COUNT);
	localparam int ADDR_W    = REG_IDX_W + 2;

	// Default shape of the table
	localparam int NUM_LEVELS_DEF       = 3;
	localparam int TIMERS_PER_LEVEL_DEF = 4;
	localparam int COUNT_WIDTH_DEF      = 8;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_START = 2'd1;
	localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_INIT  = 2'd3;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_PERIODS0 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PERIODS1 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PERIODS2 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DELAYS0  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DELAYS1  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_DELAYS2  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_CYCLIC   = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_START_EN = 3'd7;

	// Register reset values
	localparam logic [DATA_W-1:0] PERIODS0_RST = 32'd1681000965;
	localparam logic [DATA_W-1:0] PERIODS1_RST = 32'd1679034885;
	localparam logic [DATA_W-1:0] PERIODS2_RST = 32'd1679034881;
	localparam logic [DATA_W-1:0] DELAYS0_RST  = 32'd555090944;
	localparam logic [DATA_W-1:0] DELAYS1_RST  = 32'd386598914;
	localparam logic [DATA_W-1:0] DELAYS2_RST  = 32'd0;
	localparam logic [MASK_W-1:0] CYCLIC_RST   = 12'd4095;
	localparam logic [MASK_W-1:0] START_EN_RST = 12'd511;

	// Command handed from cell to cell along the chain
	typedef struct packed {
		logic               valid;
		logic [REQ_W-1:0]   req_type;
		logic [LEVEL_W-1:0] level;
		logic [SLOT_W-1:0]  slot;
	} stt_cmd_t;

endpackage

/* src/stt_intf.sv */
// Request and event channel interfaces of the timer table.
interface stt_req_if import stt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [REQ_W-1:0]   req_type;
	logic [LEVEL_W-1:0] level;
	logic [SLOT_W-1:0]  slot;

	modport source (output valid, output req_type, output level, output slot, input ready);
	modport sink (input valid, input req_type, input level, input slot, output ready);
endinterface

interface stt_evt_if import stt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [LEVEL_W-1:0]    event_level;
	logic [EVT_SLOT_W-1:0] event_slot;
	logic                  last;

	modport source (output valid, output event_level, output event_slot, output last,
		input ready);
	modport sink (input valid, input event_level, input event_slot, input last,
		output ready);
endinterface

/* src/stt_cell.sv */
// One timer slot across all levels: counts, enables and a chain stage.
module stt_cell import stt_pkg::*; #(
	parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int CELL_SLOT   = 0
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  adv,
	input  stt_cmd_t                              cmd_in,
	input  logic [NUM_LEVELS-1:0][COUNT_WIDTH-1:0] period,
	input  logic [NUM_LEVELS-1:0][COUNT_WIDTH-1:0] delay,
	input  logic [NUM_LEVELS-1:0]                 cyclic,
	input  logic [NUM_LEVELS-1:0]                 start_en,
	output stt_cmd_t                              cmd_out,
	output logic                                  expire
);

	logic [NUM_LEVELS-1:0][COUNT_WIDTH-1:0] count_q;
	logic [NUM_LEVELS-1:0]                  en_q;
	stt_cmd_t                               cmd_q;
	logic [NUM_LEVELS-1:0]                  lvl_sel;
	logic [NUM_LEVELS-1:0]                  hit;
	logic                                   act;
	logic                                   slot_sel;

	assign act      = cmd_in.valid && adv;
	assign slot_sel = cmd_in.slot == SLOT_W'(CELL_SLOT);

	// Level match and "count reaches zero on this tick" per level
	always_comb begin
		for (int l = 0; l < NUM_LEVELS; l++) begin
			lvl_sel[l] = cmd_in.level == LEVEL_W'(l);
			hit[l]     = count_q[l] <= COUNT_WIDTH'(1);
		end
	end

	assign expire = cmd_in.valid && (cmd_in.req_type == REQ_TICK) && |(lvl_sel & en_q & hit);

	// Timer state update as the command passes this cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			en_q    <= '0;
		end else if (act) begin
			for (int l = 0; l < NUM_LEVELS; l++) begin
				unique case (cmd_in.req_type)
					REQ_INIT: begin
						count_q[l] <= delay[l];
						en_q[l]    <= start_en[l];
					end
					REQ_START: begin
						if (lvl_sel[l] && slot_sel) begin
							count_q[l] <= delay[l];
							en_q[l]    <= 1'b1;
						end
					end
					REQ_STOP: begin
						if (lvl_sel[l] && slot_sel) begin
							count_q[l] <= '0;
							en_q[l]    <= 1'b0;
						end
					end
					REQ_TICK: begin
						if (lvl_sel[l] && en_q[l]) begin
							if (hit[l]) begin
								if (cyclic[l]) begin
									count_q[l] <= period[l];
								end else begin
									count_q[l] <= '0;
									en_q[l]    <= 1'b0;
								end
							end else begin
								count_q[l] <= count_q[l] - COUNT_WIDTH'(1);
							end
						end
					end
					default: begin
						count_q[l] <= count_q[l];
					end
				endcase
			end
		end
	end

	// Chain stage toward the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= '0;
		end else if (adv) begin
			cmd_q <= cmd_in;
		end
	end

	assign cmd_out = cmd_q;

endmodule

/* src/software_timer_table_unit.sv */
// Timer table top level: APB registers, cell chain and event output.
//
//  channel | direction | handshake     | payload
//  req     | in        | valid/ready   | req_type, level, slot
//  evt     | out       | valid/ready   | event_level, event_slot, last
//  apb     | in        | psel/penable  | paddr, pwdata (prdata on read)
//
// A request walks the cell chain one slot per cycle while the event register
// is not stalled, passing each cell in turn and then the
// final stage that flushes the tick's last event. The chain halts while the
// event register holds an untaken transfer. Reset clears all counts and
// enables and restores register defaults at once; no clearing pass.
module software_timer_table_unit import stt_pkg::*; #(
	parameter int NUM_LEVELS       = NUM_LEVELS_DEF,
	parameter int TIMERS_PER_LEVEL = TIMERS_PER_LEVEL_DEF,
	parameter int COUNT_WIDTH      = COUNT_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	stt_req_if.sink           req,
	stt_evt_if.source         evt
);

	localparam int TPL = TIMERS_PER_LEVEL;

	// Configuration registers
	logic [CFG_LEVELS-1:0][DATA_W-1:0] periods_q;
	logic [CFG_LEVELS-1:0][DATA_W-1:0] delays_q;
	logic [MASK_W-1:0]                 cyclic_q;
	logic [MASK_W-1:0]                 start_en_q;
	logic [REG_IDX_W-1:0]              reg_idx;
	logic                              reg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign reg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			periods_q[0] <= PERIODS0_RST;
			periods_q[1] <= PERIODS1_RST;
			periods_q[2] <= PERIODS2_RST;
			delays_q[0]  <= DELAYS0_RST;
			delays_q[1]  <= DELAYS1_RST;
			delays_q[2]  <= DELAYS2_RST;
			cyclic_q     <= CYCLIC_RST;
			start_en_q   <= START_EN_RST;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_PERIODS0: periods_q[0] <= pwdata;
				REG_PERIODS1: periods_q[1] <= pwdata;
				REG_PERIODS2: periods_q[2] <= pwdata;
				REG_DELAYS0:  delays_q[0]  <= pwdata;
				REG_DELAYS1:  delays_q[1]  <= pwdata;
				REG_DELAYS2:  delays_q[2]  <= pwdata;
				REG_CYCLIC:   cyclic_q     <= pwdata[MASK_W-1:0];
				REG_START_EN: start_en_q   <= pwdata[MASK_W-1:0];
				default:      cyclic_q     <= cyclic_q;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (reg_idx)
			REG_PERIODS0: prdata = periods_q[0];
			REG_PERIODS1: prdata = periods_q[1];
			REG_PERIODS2: prdata = periods_q[2];
			REG_DELAYS0:  prdata = delays_q[0];
			REG_DELAYS1:  prdata = delays_q[1];
			REG_DELAYS2:  prdata = delays_q[2];
			REG_CYCLIC:   prdata = DATA_W'(cyclic_q);
			REG_START_EN: prdata = DATA_W'(start_en_q);
			default:      prdata = '0;
		endcase
	end

	// Per-cell views of the configuration; levels without registers read zero
	logic [TPL-1:0][NUM_LEVELS-1:0][COUNT_WIDTH-1:0] cell_period;
	logic [TPL-1:0][NUM_LEVELS-1:0][COUNT_WIDTH-1:0] cell_delay;
	logic [TPL-1:0][NUM_LEVELS-1:0]                  cell_cyclic;
	logic [TPL-1:0][NUM_LEVELS-1:0]                  cell_start_en;

	for (genvar s = 0; s < TPL; s++) begin : g_cfg_slot
		for (genvar l = 0; l < NUM_LEVELS; l++) begin : g_cfg_level
			if (l < CFG_LEVELS) begin : g_reg
				assign cell_period[s][l]   = COUNT_WIDTH'(periods_q[l][s*FIELD_W +: FIELD_W]);
				assign cell_delay[s][l]    = COUNT_WIDTH'(delays_q[l][s*FIELD_W +: FIELD_W]);
				assign cell_cyclic[s][l]   = cyclic_q[l*MASK_STRIDE + s];
				assign cell_start_en[s][l] = start_en_q[l*MASK_STRIDE + s];
			end else begin : g_noreg
				assign cell_period[s][l]   = '0;
				assign cell_delay[s][l]    = '0;
				assign cell_cyclic[s][l]   = 1'b0;
				assign cell_start_en[s][l] = 1'b0;
			end
		end
	end

	// Flow control: chain moves only when the event register can take a transfer
	logic     adv;
	logic     busy_q;
	logic     accept;
	logic     done;
	stt_cmd_t chain_in  [TPL];
	stt_cmd_t chain_out [TPL];
	logic [TPL-1:0] expire;

	logic                  out_v_q;
	logic [LEVEL_W-1:0]    out_level_q;
	logic [EVT_SLOT_W-1:0] out_slot_q;
	logic                  out_last_q;

	assign adv       = !out_v_q || evt.ready;
	assign req.ready = !busy_q && adv;
	assign accept    = req.valid && req.ready;
	assign done      = chain_out[TPL-1].valid;

	assign chain_in[0] = '{valid: accept, req_type: req.req_type, level: req.level,
		slot: req.slot};

	// Row of cells, one per slot
	for (genvar s = 0; s < TPL; s++) begin : g_cell
		if (s > 0) begin : g_link
			assign chain_in[s] = chain_out[s-1];
		end
		stt_cell #(
			.NUM_LEVELS (NUM_LEVELS),
			.COUNT_WIDTH(COUNT_WIDTH),
			.CELL_SLOT  (s)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.cmd_in  (chain_in[s]),
			.period  (cell_period[s]),
			.delay   (cell_delay[s]),
			.cyclic  (cell_cyclic[s]),
			.start_en(cell_start_en[s]),
			.cmd_out (chain_out[s]),
			.expire  (expire[s])
		);
	end

	// Slot of the expiring cell (at most one cell is active)
	logic                  exp_any;
	logic [EVT_SLOT_W-1:0] exp_slot;

	assign exp_any = |expire;

	always_comb begin
		exp_slot = '0;
		for (int s = 0; s < TPL; s++) begin
			if (expire[s]) begin
				exp_slot = EVT_SLOT_W'(s);
			end
		end
	end

	// Busy from acceptance until the command leaves the last cell
	logic [LEVEL_W-1:0] cur_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (adv && done) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_level_q <= req.level;
		end
	end

	// One event held back until we know whether another follows
	logic                  pend_v_q;
	logic [EVT_SLOT_W-1:0] pend_slot_q;
	logic                  push;
	logic                  push_last;

	assign push      = adv && pend_v_q && (exp_any || done);
	assign push_last = !exp_any;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (adv) begin
			if (exp_any) begin
				pend_v_q <= 1'b1;
			end else if (done) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && exp_any) begin
			pend_slot_q <= exp_slot;
		end
	end

	// Event output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_level_q <= cur_level_q;
			out_slot_q  <= pend_slot_q;
			out_last_q  <= push_last;
		end
	end

	assign evt.valid       = out_v_q;
	assign evt.event_level = out_level_q;
	assign evt.event_slot  = out_slot_q;
	assign evt.last        = out_last_q;

endmodule
